### rtl/i2cpwm_pkg.sv
// Shared types, constants and table function for the I2C slave buffer / PWM block.
`timescale 1ns / 1ps
package i2cpwm_pkg;

	localparam int RX_DEPTH = 5;
	localparam int TX_DEPTH = 5;
	localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam int TX_PTR_W = $clog2(TX_DEPTH);

	localparam logic [7:0] VERSION_RESET = 8'h01;
	localparam int TX_VERSION_POS = 2;

	typedef logic [RX_PTR_W-1:0] rx_ptr_t;
	typedef logic [TX_PTR_W-1:0] tx_ptr_t;

	typedef enum logic [2:0] {
		EV_WR_ADDR,
		EV_WR_DATA,
		EV_RD_ADDR,
		EV_RD_DATA,
		EV_OTHER
	} event_t;

	// decoder result: next control state plus store and transmit requests
	typedef struct packed {
		logic    store_en;
		rx_ptr_t store_idx;
		rx_ptr_t wpos_n;
		tx_ptr_t rpos_n;
		logic    gcall_flag_n;
		logic    tx_valid;
		logic [7:0] tx_byte;
	} upd_t;

	function automatic logic [7:0] tx_table(input tx_ptr_t pos, input logic [7:0] version);
		tx_table = (pos == tx_ptr_t'(TX_VERSION_POS)) ? version : 8'h00;
	endfunction

endpackage

### rtl/i2cpwm_decode.sv
// Event classification and next-state logic for one I2C slave byte event.
`timescale 1ns / 1ps
module i2cpwm_decode import i2cpwm_pkg::*; (
	input  logic       is_data,
	input  logic       start_seen,
	input  logic       is_read,
	input  logic       buffer_full,
	input  logic [7:0] rx_byte,
	input  logic       clock_held,
	input  logic       master_nack,
	input  logic       gcall_flag,
	input  rx_ptr_t    wpos,
	input  tx_ptr_t    rpos,
	input  logic [7:0] version,
	output upd_t       upd
);

	event_t  ev;
	rx_ptr_t wp;
	rx_ptr_t wp_inc;
	tx_ptr_t rp;
	tx_ptr_t rp_inc;

	always_comb begin
		ev = EV_OTHER;
		if (!is_data && start_seen && !is_read && buffer_full) begin
			ev = EV_WR_ADDR;
		end else if (is_data && start_seen && !is_read && buffer_full) begin
			ev = EV_WR_DATA;
		end else if (!is_data && start_seen && is_read) begin
			ev = EV_RD_ADDR;
		end else if (is_data && start_seen && is_read && clock_held) begin
			ev = EV_RD_DATA;
		end
	end

	// out-of-range positions fold back to zero before use
	always_comb begin
		wp = (int'(wpos) >= RX_DEPTH) ? '0 : wpos;
		wp_inc = (wp == rx_ptr_t'(RX_DEPTH - 1)) ? '0 : wp + rx_ptr_t'(1);
		rp = (int'(rpos) >= TX_DEPTH) ? '0 : rpos;
		rp_inc = (rp == tx_ptr_t'(TX_DEPTH - 1)) ? '0 : rp + tx_ptr_t'(1);
	end

	always_comb begin
		upd.store_en     = 1'b0;
		upd.store_idx    = wp;
		upd.wpos_n       = wpos;
		upd.rpos_n       = rpos;
		upd.gcall_flag_n = gcall_flag;
		upd.tx_valid     = 1'b0;
		upd.tx_byte      = 8'h00;
		case (ev)
			EV_WR_ADDR: begin
				upd.gcall_flag_n = (rx_byte == 8'h00);
				upd.wpos_n       = '0;
			end
			EV_WR_DATA: begin
				upd.store_en = 1'b1;
				upd.wpos_n   = wp_inc;
			end
			EV_RD_ADDR: begin
				if (rx_byte == 8'h00) begin
					upd.gcall_flag_n = 1'b1;
					upd.wpos_n       = '0;
				end else begin
					upd.gcall_flag_n = 1'b0;
					upd.tx_valid     = 1'b1;
					upd.tx_byte      = tx_table('0, version);
					upd.rpos_n       = tx_ptr_t'(1);
				end
			end
			EV_RD_DATA: begin
				if (gcall_flag) begin
					upd.store_en = 1'b1;
					upd.wpos_n   = wp_inc;
				end else if (!master_nack) begin
					upd.tx_valid = 1'b1;
					upd.tx_byte  = tx_table(rp, version);
					upd.rpos_n   = rp_inc;
				end
			end
			default: begin
				if (gcall_flag) begin
					upd.store_en = 1'b1;
					upd.wpos_n   = wp_inc;
				end
			end
		endcase
	end

endmodule

### rtl/i2c_slave_buffer_pwm_control.sv
// Top level: I2C slave byte-event handler with receive buffer and PWM control.
// Each accepted input transaction is registered; its result appears on the output register in the next cycle.
// Throughput: one event per cycle; the input stalls only while a result waits
// in the output register and the output side stalls.
// Reset (arst_n low, asynchronous): control state, receive buffer and version
// register return to their defaults; no result is pending.
`timescale 1ns / 1ps
module i2c_slave_buffer_pwm_control import i2cpwm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] version_byte,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       is_data,
	input  logic       start_seen,
	input  logic       is_read,
	input  logic       buffer_full,
	input  logic [7:0] rx_byte,
	input  logic       clock_held,
	input  logic       master_nack,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic [7:0] pwm_duty,
	output logic       drive_enable,
	output logic       gencall_allowed,
	output logic       gencall_active
);

	logic [7:0] version_q;
	logic       gcall_flag_q;
	logic       gcall_en_q;
	rx_ptr_t    wpos_q;
	tx_ptr_t    rpos_q;
	logic [7:0] rx_store_q [RX_DEPTH];
	logic       out_valid_q;
	logic       tx_valid_q;
	logic [7:0] tx_byte_q;
	logic [7:0] duty_q;
	logic       gcall_active_q;

	upd_t       upd;
	logic       accept;
	logic [7:0] duty_n;
	logic       gcall_en_n;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;

	i2cpwm_decode u_decode (
		.is_data     (is_data),
		.start_seen  (start_seen),
		.is_read     (is_read),
		.buffer_full (buffer_full),
		.rx_byte     (rx_byte),
		.clock_held  (clock_held),
		.master_nack (master_nack),
		.gcall_flag  (gcall_flag_q),
		.wpos        (wpos_q),
		.rpos        (rpos_q),
		.version     (version_q),
		.upd         (upd)
	);

	// receive byte 0 as it stands after this event
	always_comb begin
		duty_n = rx_store_q[0];
		if (upd.store_en && upd.store_idx == '0) begin
			duty_n = rx_byte;
		end
		gcall_en_n = gcall_en_q && (duty_n == 8'h00);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q    <= VERSION_RESET;
			gcall_flag_q <= 1'b0;
			gcall_en_q   <= 1'b1;
			wpos_q       <= '0;
			rpos_q       <= '0;
			for (int i = 0; i < RX_DEPTH; i++) begin
				rx_store_q[i] <= 8'h00;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				version_q <= version_byte;
			end
			if (accept) begin
				gcall_flag_q <= upd.gcall_flag_n;
				gcall_en_q   <= gcall_en_n;
				wpos_q       <= upd.wpos_n;
				rpos_q       <= upd.rpos_n;
				if (upd.store_en) begin
					rx_store_q[upd.store_idx] <= rx_byte;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!in_stall) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tx_valid_q     <= upd.tx_valid;
			tx_byte_q      <= upd.tx_byte;
			duty_q         <= duty_n;
			gcall_active_q <= upd.gcall_flag_n;
		end
	end

	assign out_valid       = out_valid_q;
	assign tx_valid        = tx_valid_q;
	assign tx_byte         = tx_byte_q;
	assign pwm_duty        = duty_q;
	assign drive_enable    = (duty_q != 8'h00);
	assign gencall_allowed = gcall_en_q;
	assign gencall_active  = gcall_active_q;

endmodule

### rtl/i2cpwm_checker.sv
// Port-level assertions for the I2C slave buffer / PWM block, bound to the top level.
`timescale 1ns / 1ps
module i2cpwm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       tx_valid,
	input logic [7:0] tx_byte,
	input logic [7:0] pwm_duty,
	input logic       drive_enable,
	input logic       gencall_allowed
);

	// nothing loaded means a zero byte
	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> tx_byte == 8'h00)
		else $error("tx_byte nonzero without tx_valid");

	a_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive_enable == (pwm_duty != 8'h00))
		else $error("drive_enable disagrees with pwm_duty");

	// a nonzero duty has already withdrawn general call
	a_gcall_dis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pwm_duty != 8'h00 |-> !gencall_allowed)
		else $error("general call still allowed with nonzero duty");

	// once withdrawn, general call stays withdrawn until reset
	a_gcall_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !gencall_allowed |=> !gencall_allowed)
		else $error("general call enable came back");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(pwm_duty))
		else $error("stalled result changed");

endmodule

bind i2c_slave_buffer_pwm_control i2cpwm_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.tx_valid        (tx_valid),
	.tx_byte         (tx_byte),
	.pwm_duty        (pwm_duty),
	.drive_enable    (drive_enable),
	.gencall_allowed (gencall_allowed)
);

### verif/tb.sv
// Testbench for the I2C slave buffer / PWM block: table-driven and random byte events against a predictor.
`timescale 1ns / 1ps
module tb;
	import i2cpwm_pkg::*;

	typedef struct packed {
		logic       is_data;
		logic       start_seen;
		logic       is_read;
		logic       buffer_full;
		logic [7:0] rx_byte;
		logic       clock_held;
		logic       master_nack;
	} bus_event_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic [7:0] pwm_duty;
		logic       drive_enable;
		logic       gencall_allowed;
		logic       gencall_active;
	} slave_status_t;

	typedef struct {
		bus_event_t    ev;
		bit            typed;
		slave_status_t want;
	} dir_row_t;

	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 265;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] version_byte = VERSION_RESET;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       is_data = 1'b0;
	logic       start_seen = 1'b0;
	logic       is_read = 1'b0;
	logic       buffer_full = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic       clock_held = 1'b0;
	logic       master_nack = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic [7:0] pwm_duty;
	logic       drive_enable;
	logic       gencall_allowed;
	logic       gencall_active;

	i2c_slave_buffer_pwm_control i_dut (
		.clk,
		.arst_n,
		.cfg_valid,
		.cfg_ready,
		.version_byte,
		.in_valid,
		.in_stall,
		.is_data,
		.start_seen,
		.is_read,
		.buffer_full,
		.rx_byte,
		.clock_held,
		.master_nack,
		.out_valid,
		.out_stall,
		.tx_valid,
		.tx_byte,
		.pwm_duty,
		.drive_enable,
		.gencall_allowed,
		.gencall_active
	);

	// predicted slave state
	logic       gc_flag;
	logic       gc_en;
	int         wr_pos;
	int         rd_pos;
	logic [7:0] rx_mem [RX_DEPTH];
	logic [7:0] version_q;

	slave_status_t status_q [$];
	dir_row_t      dir_tab [$];
	int            fails = 0;
	int            items_sent = 0;
	bit            calm = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: FAIL");
		$finish;
	end

	function automatic bus_event_t bus_ev(logic d, logic s, logic r, logic b, logic [7:0] rx,
			logic h, logic n);
		bus_event_t e;
		e = '{is_data: d, start_seen: s, is_read: r, buffer_full: b, rx_byte: rx,
			clock_held: h, master_nack: n};
		return e;
	endfunction

	function automatic slave_status_t status_of(logic v, logic [7:0] b, logic [7:0] d, logic en,
			logic al, logic ac);
		slave_status_t s;
		s = '{tx_valid: v, tx_byte: b, pwm_duty: d, drive_enable: en, gencall_allowed: al,
			gencall_active: ac};
		return s;
	endfunction

	function automatic void add_row(bus_event_t e, bit typed, slave_status_t w);
		dir_row_t row;
		row.ev = e;
		row.typed = typed;
		row.want = w;
		dir_tab.push_back(row);
	endfunction

	function automatic logic coin();
		return logic'($urandom_range(0, 1));
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic event_t decode_event(bus_event_t e);
		if ({e.is_data, e.start_seen, e.is_read, e.buffer_full} == 4'b0101)
			return EV_WR_ADDR;
		if ({e.is_data, e.start_seen, e.is_read, e.buffer_full} == 4'b1101)
			return EV_WR_DATA;
		if ({e.is_data, e.start_seen, e.is_read} == 3'b011)
			return EV_RD_ADDR;
		if ({e.is_data, e.start_seen, e.is_read} == 3'b111 && e.clock_held)
			return EV_RD_DATA;
		return EV_OTHER;
	endfunction

	function automatic logic [7:0] tx_rom_byte(int pos);
		return (pos == TX_VERSION_POS) ? version_q : 8'h00;
	endfunction

	function automatic void keep_byte(logic [7:0] b);
		rx_mem[wr_pos] = b;
		wr_pos = (wr_pos == RX_DEPTH - 1) ? 0 : wr_pos + 1;
	endfunction

	function automatic slave_status_t apply_event(bus_event_t e);
		slave_status_t r;
		r = '0;
		case (decode_event(e))
			EV_WR_ADDR: begin
				gc_flag = (e.rx_byte == 8'h00);
				wr_pos = 0;
			end
			EV_WR_DATA: keep_byte(e.rx_byte);
			EV_RD_ADDR: begin
				if (e.rx_byte == 8'h00) begin
					gc_flag = 1'b1;
					wr_pos = 0;
				end else begin
					gc_flag = 1'b0;
					r.tx_valid = 1'b1;
					r.tx_byte = tx_rom_byte(0);
					rd_pos = 1;
				end
			end
			EV_RD_DATA: begin
				// general call redirects read-side bytes into the receive buffer
				if (gc_flag) begin
					keep_byte(e.rx_byte);
				end else if (!e.master_nack) begin
					r.tx_valid = 1'b1;
					r.tx_byte = tx_rom_byte(rd_pos);
					rd_pos = (rd_pos == TX_DEPTH - 1) ? 0 : rd_pos + 1;
				end
			end
			default: begin
				if (gc_flag)
					keep_byte(e.rx_byte);
			end
		endcase
		if (rx_mem[0] != 8'h00)
			gc_en = 1'b0;
		r.pwm_duty = rx_mem[0];
		r.drive_enable = (rx_mem[0] != 8'h00);
		r.gencall_allowed = gc_en;
		r.gencall_active = gc_flag;
		return r;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endfunction

	task automatic send_event(input bus_event_t e, input bit typed, input slave_status_t want);
		slave_status_t predicted;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		is_data <= e.is_data;
		start_seen <= e.start_seen;
		is_read <= e.is_read;
		buffer_full <= e.buffer_full;
		rx_byte <= e.rx_byte;
		clock_held <= e.clock_held;
		master_nack <= e.master_nack;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = apply_event(e);
		status_q.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	task automatic set_version(input logic [7:0] v);
		cfg_valid <= 1'b1;
		version_byte <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		version_q = v;
	endtask

	task automatic write_burst();
		int n;
		n = $urandom_range(0, 7);
		send_event(bus_ev(1'b0, 1'b1, 1'b0, 1'b1, ($urandom_range(0, 5) == 0) ? 8'h00 : rand_byte(),
			coin(), coin()), 1'b0, '0);
		repeat (n) send_event(bus_ev(1'b1, 1'b1, 1'b0, 1'b1, rand_byte(), coin(), coin()), 1'b0, '0);
		// closing NACK or stray event; stored when the transfer was a general call
		if ($urandom_range(0, 2) == 0)
			send_event(bus_ev(coin(), 1'b0, coin(), coin(), rand_byte(), coin(), 1'b1), 1'b0, '0);
	endtask

	task automatic read_burst();
		int n;
		n = $urandom_range(0, 7);
		send_event(bus_ev(1'b0, 1'b1, 1'b1, coin(), ($urandom_range(0, 7) == 0) ? 8'h00 : rand_byte(),
			coin(), coin()), 1'b0, '0);
		for (int i = 0; i < n; i++)
			send_event(bus_ev(1'b1, 1'b1, 1'b1, coin(), rand_byte(), 1'b1,
				(i == n - 1) ? coin() : logic'($urandom_range(0, 9) == 0)), 1'b0, '0);
	endtask

	task automatic noise_burst();
		logic [31:0] raw;
		bus_event_t  e;
		repeat ($urandom_range(1, 4)) begin
			raw = $urandom;
			e = raw[$bits(bus_event_t)-1:0];
			send_event(e, 1'b0, '0);
		end
	endtask

	initial begin : sink_pacing
		int run;
		forever begin
			if (calm) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				run = $urandom_range(1, 12);
				out_stall <= ($urandom_range(0, 2) == 0);
				repeat (run) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : result_check
		slave_status_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (status_q.size() == 0) begin
				$error("result with no transaction pending: tx_byte %0h, pwm_duty %0h",
					tx_byte, pwm_duty);
				fails++;
			end else begin
				w = status_q.pop_front();
				check_field("tx_valid", 8'(w.tx_valid), 8'(tx_valid));
				check_field("tx_byte", w.tx_byte, tx_byte);
				check_field("pwm_duty", w.pwm_duty, pwm_duty);
				check_field("drive_enable", 8'(w.drive_enable), 8'(drive_enable));
				check_field("gencall_allowed", 8'(w.gencall_allowed), 8'(gencall_allowed));
				check_field("gencall_active", 8'(w.gencall_active), 8'(gencall_active));
			end
		end
	end

	initial begin : stimulus
		int target;
		gc_flag = 1'b0;
		gc_en = 1'b1;
		wr_pos = 0;
		rd_pos = 0;
		foreach (rx_mem[i])
			rx_mem[i] = 8'h00;
		version_q = VERSION_RESET;

		// read data before any read address starts at table position zero
		add_row(bus_ev(1, 1, 1, 1, 8'h3C, 1, 0), 1, status_of(1, 8'h00, 8'h00, 0, 1, 0));
		add_row(bus_ev(0, 1, 1, 0, 8'hA5, 0, 0), 1, status_of(1, 8'h00, 8'h00, 0, 1, 0));
		add_row(bus_ev(1, 1, 1, 0, 8'h00, 1, 0), 1, status_of(1, 8'h00, 8'h00, 0, 1, 0));
		add_row(bus_ev(1, 1, 1, 1, 8'hFF, 1, 0), 1, status_of(1, VERSION_RESET, 8'h00, 0, 1, 0));
		add_row(bus_ev(1, 1, 1, 1, 8'h00, 1, 1), 1, status_of(0, 8'h00, 8'h00, 0, 1, 0));
		// read data without clock hold falls through to no effect
		add_row(bus_ev(1, 1, 1, 0, 8'h77, 0, 0), 1, status_of(0, 8'h00, 8'h00, 0, 1, 0));
		// read index runs past the end of the table and wraps
		add_row(bus_ev(1, 1, 1, 1, 8'h12, 1, 0), 0, '0);
		add_row(bus_ev(1, 1, 1, 1, 8'hED, 1, 0), 0, '0);
		add_row(bus_ev(1, 1, 1, 1, 8'h40, 1, 0), 0, '0);
		// general call, then stray and read-side bytes land in the buffer
		add_row(bus_ev(0, 1, 0, 1, 8'h00, 1, 1), 1, status_of(0, 8'h00, 8'h00, 0, 1, 1));
		add_row(bus_ev(1, 0, 0, 0, 8'h00, 0, 1), 1, status_of(0, 8'h00, 8'h00, 0, 1, 1));
		add_row(bus_ev(1, 1, 1, 1, 8'h81, 1, 1), 0, '0);
		add_row(bus_ev(0, 1, 1, 1, 8'h00, 0, 0), 1, status_of(0, 8'h00, 8'h00, 0, 1, 1));
		add_row(bus_ev(0, 1, 1, 0, 8'hFF, 1, 1), 0, '0);
		add_row(bus_ev(0, 1, 0, 1, 8'h50, 0, 0), 0, '0);
		add_row(bus_ev(1, 1, 0, 1, 8'h00, 0, 0), 0, '0);
		add_row(bus_ev(1, 1, 0, 1, 8'hFF, 1, 1), 0, '0);
		add_row(bus_ev(1, 1, 0, 1, 8'h01, 0, 1), 0, '0);
		add_row(bus_ev(1, 1, 0, 1, 8'h80, 1, 0), 0, '0);
		add_row(bus_ev(1, 1, 0, 1, 8'h7E, 0, 0), 0, '0);
		// wraps onto byte 0: duty goes nonzero and general call is disabled for good
		add_row(bus_ev(1, 1, 0, 1, 8'hFC, 0, 0), 0, '0);
		// general call still decoded while disallowed
		add_row(bus_ev(0, 1, 0, 1, 8'h00, 0, 0), 0, '0);
		add_row(bus_ev(0, 0, 0, 0, 8'h33, 0, 0), 0, '0);
		add_row(bus_ev(1, 1, 0, 1, 8'h00, 1, 1), 0, '0);
		add_row(bus_ev(0, 1, 0, 1, 8'h01, 1, 0), 0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_event(dir_tab[i].ev, dir_tab[i].typed, dir_tab[i].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			calm = (ph == PHASES - 1);
			in_valid <= 1'b0;
			@(posedge clk);
			while (status_q.size() != 0) @(posedge clk);
			set_version((ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : 8'($urandom_range(1, 254)));
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: write_burst();
					4, 5, 6, 7: read_burst();
					default: noise_burst();
				endcase
			end
		end

		in_valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

### filelist.f
rtl/i2cpwm_pkg.sv
rtl/i2cpwm_decode.sv
rtl/i2c_slave_buffer_pwm_control.sv
rtl/i2cpwm_checker.sv
verif/tb.sv
